>>> hw/rtl/itda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_pkg
// Shared constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

    // Default build: 32-bit signed values, up to ten decimal digits
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 10;

    // Entries in the queue between front end and back end
    localparam int QUEUE_DEPTH_DEF = 2;

    // Binary bits folded into the BCD digits per conversion cycle
    localparam int DABBLE_BITS = 8;

    // Widths of a BCD digit and of an output character
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    // BCD shift-and-add-three adjustment
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

endpackage

>>> hw/rtl/itda_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_front
// Front end: accepts a signed value, splits it into sign and unsigned
// magnitude and pushes the pair into the work queue.
// ----------------------------------------------------------------------------
module itda_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output logic [VALUE_BITS:0]   o_push_data
);

    logic                  neg;
    logic [VALUE_BITS-1:0] mag;

    // Classify: the sign bit selects the two's complement magnitude.
    // The most negative value wraps to 2^(VALUE_BITS-1), exact as unsigned.
    assign neg = i_value[VALUE_BITS-1];
    assign mag = neg ? (~i_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : i_value;

    // Pass the request on whenever the queue has room
    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;
    assign o_push_data  = {neg, mag};

endmodule

>>> hw/rtl/itda_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_queue
// Small first-in first-out queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module itda_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Hold pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> hw/rtl/itda_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_back
// Back end: converts a magnitude to BCD digits by shift-and-add-three,
// finds the leading digit, then emits sign and digits one per cycle,
// while the output side accepts them, through an output register.
// ----------------------------------------------------------------------------
module itda_back #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_pop_valid,
    output logic                      o_pop_ready,
    input  logic [VALUE_BITS:0]       i_pop_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [itda_pkg::CHAR_W-1:0] o_char_code,
    output logic                      o_last_char
);

    import itda_pkg::*;

    localparam int STEPS     = (VALUE_BITS + DABBLE_BITS - 1) / DABBLE_BITS;
    localparam int PAD_W     = STEPS * DABBLE_BITS;
    localparam int STEP_W    = $clog2(STEPS + 1);
    localparam int DIG_IDX_W = $clog2(MAX_DIGITS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_FIND = 4'b0100,
        S_EMIT = 4'b1000
    } t_back_state;

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] t_digits;

    t_back_state          r_state, n_state;
    logic [STEP_W-1:0]    r_steps, n_steps;
    logic [DIG_IDX_W-1:0] r_idx, n_idx;
    logic                 r_sign_pending, n_sign_pending;
    logic                 r_neg, n_neg;
    logic                 r_ovf, n_ovf;
    logic                 r_out_valid, n_out_valid;
    logic [PAD_W-1:0]     r_bin, n_bin;
    t_digits              r_digits, n_digits;
    logic [CHAR_W-1:0]    r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    t_digits              dab_digits;
    logic [PAD_W-1:0]     dab_bin;
    logic                 dab_ovf;
    logic [DIG_IDX_W-1:0] top_idx;
    logic                 slot_free;

    function automatic logic f_all_bcd(input t_digits d);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (d[i] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    assign o_pop_ready = (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_char_code = r_out_char;
    assign o_last_char = r_out_last;

    // Fold DABBLE_BITS binary bits into the digits; record bits lost off the top
    always_comb begin
        dab_digits = r_digits;
        dab_bin    = r_bin;
        dab_ovf    = r_ovf;
        for (int s = 0; s < DABBLE_BITS; s++) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                if (dab_digits[d] >= BCD_ADJ_MIN) begin
                    dab_digits[d] = dab_digits[d] + BCD_ADJ;
                end
            end
            dab_ovf = dab_ovf | dab_digits[MAX_DIGITS-1][DIGIT_W-1];
            for (int d = MAX_DIGITS - 1; d > 0; d--) begin
                dab_digits[d] = {dab_digits[d][DIGIT_W-2:0], dab_digits[d-1][DIGIT_W-1]};
            end
            dab_digits[0] = {dab_digits[0][DIGIT_W-2:0], dab_bin[PAD_W-1]};
            dab_bin       = {dab_bin[PAD_W-2:0], 1'b0};
        end
    end

    // Locate the most significant non-zero digit; all digits kept on overflow
    always_comb begin
        top_idx = '0;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_digits[d] != '0) begin
                top_idx = DIG_IDX_W'(d);
            end
        end
        if (r_ovf) begin
            top_idx = DIG_IDX_W'(MAX_DIGITS - 1);
        end
    end

    // Sequence load, conversion, search and emission
    always_comb begin
        n_state        = r_state;
        n_steps        = r_steps;
        n_idx          = r_idx;
        n_sign_pending = r_sign_pending;
        n_neg          = r_neg;
        n_ovf          = r_ovf;
        n_bin          = r_bin;
        n_digits       = r_digits;
        n_out_valid    = r_out_valid && !i_ready;
        n_out_char     = r_out_char;
        n_out_last     = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_neg          = i_pop_data[VALUE_BITS];
                    n_sign_pending = i_pop_data[VALUE_BITS];
                    n_bin          = PAD_W'(i_pop_data[VALUE_BITS-1:0]);
                    n_digits       = '0;
                    n_ovf          = 1'b0;
                    n_steps        = STEP_W'(STEPS);
                    n_state        = S_CONV;
                end
            end
            S_CONV: begin
                n_digits = dab_digits;
                n_bin    = dab_bin;
                n_ovf    = dab_ovf;
                n_steps  = r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_idx   = top_idx;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_sign_pending) begin
                        n_out_char     = CHAR_MINUS;
                        n_out_last     = 1'b0;
                        n_sign_pending = 1'b0;
                    end else begin
                        n_out_char = CHAR_ZERO + {4'd0, r_digits[r_idx]};
                        n_out_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx - DIG_IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sign_pending <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_sign_pending <= n_sign_pending;
            r_out_valid    <= n_out_valid;
        end
    end

    // Working and payload registers, including the digit store
    always_ff @(posedge i_clk) begin
        r_steps    <= n_steps;
        r_idx      <= n_idx;
        r_neg      <= n_neg;
        r_ovf      <= n_ovf;
        r_bin      <= n_bin;
        r_digits   <= n_digits;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // A pending sign only ever belongs to a negative value
    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sign_pending |-> r_neg)
        else $error("sign pending for a non-negative value");

    // Conversion leaves only valid decimal digits
    a_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> f_all_bcd(r_digits))
        else $error("digit store holds a non-decimal digit");

    // The units digit closes the text and frees the back end
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && slot_free && !r_sign_pending && r_idx == '0)
        |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final digit not flagged or back end not released");

    // A minus sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_char == CHAR_MINUS) |-> !r_out_last)
        else $error("minus sign flagged as last character");

    // Conversion never runs with an exhausted step count
    a_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (r_steps != '0))
        else $error("conversion step count exhausted");

endmodule

>>> hw/rtl/int_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// Signed integer to decimal ASCII text, one character per output request.
// ----------------------------------------------------------------------------
// Each input request carries one signed two's complement value; the block
// returns its decimal text most significant character first, with a leading
// '-' for negative values, a single '0' for zero, and o_last_char high on the
// final character. The front end takes one value per cycle into a two-entry
// queue while it has room. The back end handles one value at a time: it
// loads the value, converts it to BCD digits by shift-and-add-three, finds
// the leading digit, and then emits the sign and digits in order while the
// output side takes each character as it is offered.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_core #(
    parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = itda_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [VALUE_BITS-1:0]       i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [itda_pkg::CHAR_W-1:0] o_char_code,
    output logic                        o_last_char
);

    import itda_pkg::*;

    logic                push_valid;
    logic                push_ready;
    logic [VALUE_BITS:0] push_data;
    logic                pop_valid;
    logic                pop_ready;
    logic [VALUE_BITS:0] pop_data;

    // Classify incoming values
    itda_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // Decouple front and back end
    itda_queue #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // Convert and emit characters
    itda_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule
